>>> rtl/pid_controller_inc_pos_core_defines.svh
// Assertion macros shared by the PID controller RTL.
`ifndef PID_CONTROLLER_INC_POS_CORE_DEFINES_SVH
`define PID_CONTROLLER_INC_POS_CORE_DEFINES_SVH

`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define PIDIP_ASSERT_SAME(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("pid controller check failed");
// The consequent must hold in the cycle after the antecedent.
`define PIDIP_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("pid controller check failed");
`else
`define PIDIP_ASSERT_SAME(lbl, ck, rs, ante, cons)
`define PIDIP_ASSERT_NEXT(lbl, ck, rs, ante, cons)
`endif

`endif

>>> rtl/pidip_pkg.sv
// Types and constants of the PID controller.
package pidip_pkg;

  localparam int GAIN_W      = 16;
  localparam int OUT_LIMIT_W = 15;
  localparam int ILIM_W      = 20;
  localparam int INTEG_W     = ILIM_W + 1;
  localparam int ACC_FRAC    = 8;
  localparam int ACC_W       = OUT_LIMIT_W + ACC_FRAC + 2;
  localparam int DRIVE_W     = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = ILIM_W;

  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KP_GAIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KI_GAIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KD_GAIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INT_LIMIT = 3'd5;

  localparam logic MODE_INCREMENTAL = 1'b0;
  localparam logic MODE_POSITIONAL  = 1'b1;

  localparam logic [GAIN_W-1:0]      RST_KP_GAIN   = 16'd3840;
  localparam logic [GAIN_W-1:0]      RST_KI_GAIN   = 16'd128;
  localparam logic [GAIN_W-1:0]      RST_KD_GAIN   = 16'd128;
  localparam logic [OUT_LIMIT_W-1:0] RST_OUT_LIMIT = 15'd16384;
  localparam logic [ILIM_W-1:0]      RST_INT_LIMIT = 20'd5000;

  typedef struct packed {
    logic                   mode;
    logic [GAIN_W-1:0]      kp_gain;
    logic [GAIN_W-1:0]      ki_gain;
    logic [GAIN_W-1:0]      kd_gain;
    logic [OUT_LIMIT_W-1:0] out_limit;
    logic [ILIM_W-1:0]      integral_limit;
  } cfg_t;

endpackage

>>> rtl/pidip_cfg_regs.sv
// Configuration register file of the PID controller.
module pidip_cfg_regs
  import pidip_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode           <= MODE_INCREMENTAL;
      cfg.kp_gain        <= RST_KP_GAIN;
      cfg.ki_gain        <= RST_KI_GAIN;
      cfg.kd_gain        <= RST_KD_GAIN;
      cfg.out_limit      <= RST_OUT_LIMIT;
      cfg.integral_limit <= RST_INT_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MODE:      cfg.mode           <= cfg_data[0];
        REG_KP_GAIN:   cfg.kp_gain        <= cfg_data[GAIN_W-1:0];
        REG_KI_GAIN:   cfg.ki_gain        <= cfg_data[GAIN_W-1:0];
        REG_KD_GAIN:   cfg.kd_gain        <= cfg_data[GAIN_W-1:0];
        REG_OUT_LIMIT: cfg.out_limit      <= cfg_data[OUT_LIMIT_W-1:0];
        REG_INT_LIMIT: cfg.integral_limit <= cfg_data[ILIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

>>> rtl/pidip_datapath.sv
// Control law arithmetic and controller state of the PID controller.
module pidip_datapath
  import pidip_pkg::*;
#(
  parameter int DATA_WIDTH     = 16,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic [DATA_WIDTH-1:0] setpoint_q,
  input  logic [DATA_WIDTH-1:0] feedback_q,
  input  cfg_t                  cfg,
  output logic [DRIVE_W-1:0]    res_drive,
  output logic                  res_sat
);

  localparam int EW  = DATA_WIDTH + 1;
  localparam int D1W = DATA_WIDTH + 2;
  localparam int D2W = DATA_WIDTH + 3;
  localparam int OPW = (D2W > INTEG_W) ? D2W : INTEG_W;
  localparam int IRW = ((EW > INTEG_W) ? EW : INTEG_W) + 1;
  localparam int PW  = GAIN_W + 1 + OPW;
  localparam int SW  = PW + 2;
  localparam int AW  = SW + ACC_FRAC + 2;

  logic signed [EW-1:0]      err_last;
  logic signed [EW-1:0]      err_before_last;
  logic signed [D1W-1:0]     delta_last;
  logic signed [INTEG_W-1:0] integral_sum;
  logic signed [ACC_W-1:0]   output_accum;

  logic signed [EW-1:0]      e0;
  logic signed [D1W-1:0]     d0;
  logic signed [D2W-1:0]     dd;
  logic signed [D2W-1:0]     d2;
  logic signed [IRW-1:0]     integ_raw;
  logic signed [IRW-1:0]     integ_lim;
  logic signed [INTEG_W-1:0] integ;
  logic signed [OPW-1:0]     op_p;
  logic signed [OPW-1:0]     op_i;
  logic signed [OPW-1:0]     op_d;
  logic signed [GAIN_W:0]    kp_s;
  logic signed [GAIN_W:0]    ki_s;
  logic signed [GAIN_W:0]    kd_s;
  logic signed [PW-1:0]      prod_p;
  logic signed [PW-1:0]      prod_i;
  logic signed [PW-1:0]      prod_d;
  logic signed [PW-1:0]      ilim;
  logic signed [PW-1:0]      term_i;
  logic signed [SW-1:0]      sum;
  logic signed [AW-1:0]      sum_acc;
  logic signed [AW-1:0]      acc_pre;
  logic signed [AW-1:0]      olim;
  logic signed [AW-1:0]      acc;
  logic                      incr;

  assign incr = (cfg.mode == MODE_INCREMENTAL);

  always_comb begin
    e0 = EW'($signed(setpoint_q)) - EW'($signed(feedback_q));
    d0 = D1W'(e0) - D1W'(err_last);
    dd = D2W'(d0) - D2W'(delta_last);
    d2 = D2W'(e0) - (D2W'(err_last) <<< 1) + D2W'(err_before_last);

    integ_raw = IRW'(integral_sum) + IRW'(e0);
    integ_lim = IRW'(cfg.integral_limit);
    if (integ_raw > integ_lim) begin
      integ = INTEG_W'(integ_lim);
    end else if (integ_raw < -integ_lim) begin
      integ = INTEG_W'(-integ_lim);
    end else begin
      integ = INTEG_W'(integ_raw);
    end

    op_p = incr ? OPW'(d0) : OPW'(e0);
    op_i = incr ? OPW'(e0) : OPW'(integ);
    op_d = incr ? OPW'(dd) : OPW'(d2);

    kp_s = $signed({1'b0, cfg.kp_gain});
    ki_s = $signed({1'b0, cfg.ki_gain});
    kd_s = $signed({1'b0, cfg.kd_gain});

    prod_p = PW'(kp_s) * PW'(op_p);
    prod_i = PW'(ki_s) * PW'(op_i);
    prod_d = PW'(kd_s) * PW'(op_d);

    ilim = PW'(cfg.integral_limit) <<< GAIN_FRAC_BITS;
    term_i = prod_i;
    if (incr) begin
      if (prod_i > ilim) begin
        term_i = ilim;
      end else if (prod_i < -ilim) begin
        term_i = -ilim;
      end
    end

    sum = SW'(prod_p) + SW'(term_i) + SW'(prod_d);
  end

  generate
    if (GAIN_FRAC_BITS > ACC_FRAC) begin : g_shr
      assign sum_acc = AW'(sum >>> (GAIN_FRAC_BITS - ACC_FRAC));
    end else begin : g_shl
      assign sum_acc = AW'(sum) <<< (ACC_FRAC - GAIN_FRAC_BITS);
    end
  endgenerate

  always_comb begin
    acc_pre = incr ? (AW'(output_accum) + sum_acc) : sum_acc;
    olim    = AW'(cfg.out_limit) <<< ACC_FRAC;
    res_sat = 1'b0;
    if (acc_pre > olim) begin
      acc     = olim;
      res_sat = 1'b1;
    end else if (acc_pre < -olim) begin
      acc     = -olim;
      res_sat = 1'b1;
    end else begin
      acc = acc_pre;
    end
    res_drive = acc[ACC_FRAC +: DRIVE_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      err_last        <= '0;
      err_before_last <= '0;
      delta_last      <= '0;
      integral_sum    <= '0;
      output_accum    <= '0;
    end else if (adv) begin
      err_last        <= e0;
      err_before_last <= err_last;
      delta_last      <= d0;
      output_accum    <= ACC_W'(acc);
      if (!incr) begin
        integral_sum <= integ;
      end
    end
  end

endmodule

>>> rtl/pid_controller_inc_pos_core.sv
// An accepted input is held in the input register; its result enters the result
// register when the item advances, which a held result can delay.
// Throughput: one item per cycle, set by one combinational pass of the control law
// between the input register and the result register; a held result stalls the input.
// Reset clears the controller state and both valid flags, and restores the
// configuration registers to their documented values.
`include "pid_controller_inc_pos_core_defines.svh"

module pid_controller_inc_pos_core
  import pidip_pkg::*;
#(
  parameter int DATA_WIDTH     = 16,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [DATA_WIDTH-1:0] setpoint,
  input  logic [DATA_WIDTH-1:0] feedback,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DRIVE_W-1:0]    drive,
  output logic                  saturated,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t                  cfg;
  logic                  in_full;
  logic [DATA_WIDTH-1:0] setpoint_q;
  logic [DATA_WIDTH-1:0] feedback_q;
  logic                  adv;
  logic                  in_take;
  logic [DRIVE_W-1:0]    res_drive;
  logic                  res_sat;

  assign adv      = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !adv;
  assign in_take  = in_valid && !in_stall;

  pidip_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pidip_datapath #(
    .DATA_WIDTH     (DATA_WIDTH),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .setpoint_q (setpoint_q),
    .feedback_q (feedback_q),
    .cfg        (cfg),
    .res_drive  (res_drive),
    .res_sat    (res_sat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (adv) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      setpoint_q <= setpoint;
      feedback_q <= feedback;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      drive     <= res_drive;
      saturated <= res_sat;
    end
  end

  `PIDIP_ASSERT_SAME(a_stall_needs_item, clk, rst, in_stall, in_full)
  `PIDIP_ASSERT_NEXT(a_adv_gives_result, clk, rst, adv, out_valid)
  `PIDIP_ASSERT_NEXT(a_blocked_item_kept, clk, rst, in_full && out_valid && out_stall, in_full)

endmodule
